// File: rtl/ndefp_pkg.sv
// ----------------------------------------------------------------------------
// NDEF message parser package
// Shared types and constants: parse state, per-byte result, register set,
// header flag positions, byte kinds, error codes and phase codes.
// ----------------------------------------------------------------------------
package ndefp_pkg;

    // Parse phase codes.
    localparam logic [2:0] PH_HEAD = 3'd0;
    localparam logic [2:0] PH_TLEN = 3'd1;
    localparam logic [2:0] PH_PLEN = 3'd2;
    localparam logic [2:0] PH_ILEN = 3'd3;
    localparam logic [2:0] PH_TYPE = 3'd4;
    localparam logic [2:0] PH_ID   = 3'd5;
    localparam logic [2:0] PH_PAY  = 3'd6;

    // Bit positions of the header flags.
    localparam int unsigned FLAG_MB = 7;
    localparam int unsigned FLAG_ME = 6;
    localparam int unsigned FLAG_CF = 5;
    localparam int unsigned FLAG_SR = 4;
    localparam int unsigned FLAG_IL = 3;

    // Type name format codes.
    localparam logic [2:0] TNF_VOID      = 3'd0;
    localparam logic [2:0] TNF_WKT       = 3'd1;
    localparam logic [2:0] TNF_MEDIA     = 3'd2;
    localparam logic [2:0] TNF_URI       = 3'd3;
    localparam logic [2:0] TNF_EXTERNAL  = 3'd4;
    localparam logic [2:0] TNF_OPAQUE    = 3'd5;
    localparam logic [2:0] TNF_CONT      = 3'd6;
    localparam logic [2:0] TNF_SPARE     = 3'd7;

    // Byte kinds.
    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_TLEN    = 3'd1;
    localparam logic [2:0] KIND_PLEN    = 3'd2;
    localparam logic [2:0] KIND_ILEN    = 3'd3;
    localparam logic [2:0] KIND_TYPE    = 3'd4;
    localparam logic [2:0] KIND_ID      = 3'd5;
    localparam logic [2:0] KIND_PAYLOAD = 3'd6;
    localparam logic [2:0] KIND_IGNORED = 3'd7;

    // Error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_FLAGS     = 3'd1;
    localparam logic [2:0] ERR_LENGTH    = 3'd2;
    localparam logic [2:0] ERR_OVER      = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;
    localparam logic [2:0] ERR_MISSING   = 3'd5;

    // Register indexes on the configuration port.
    localparam logic REG_MAX_PAYLOAD = 1'b0;
    localparam logic REG_SINGLE      = 1'b1;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;
    localparam logic [7:0]  BYTE_MASK         = 8'hFF;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  header_flags;
        logic [7:0]  type_count;
        logic [7:0]  id_count;
        logic [31:0] payload_count;
        logic [1:0]  length_byte_index;
        logic [31:0] merged_length;
        logic        chunk_open;
        logic [2:0]  chunk_format;
        logic        record_seen;
        logic        halted;
        logic        kept_type;
        logic        kept_id;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase: PH_HEAD, header_flags: 8'd0, type_count: 8'd0, id_count: 8'd0,
        payload_count: 32'd0, length_byte_index: 2'd0, merged_length: 32'd0,
        chunk_open: 1'b0, chunk_format: 3'd0, record_seen: 1'b0,
        halted: 1'b0, kept_type: 1'b0, kept_id: 1'b0
    };

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] byte_kind;
        logic [2:0] record_tnf;
        logic       record_start;
        logic       record_end;
        logic       tnf_ok;
        logic       message_done;
        logic [2:0] error_code;
    } byte_result_t;

    typedef struct packed {
        logic [31:0] max_payload;
        logic        single_record_mode;
    } parser_cfg_t;

endpackage

// File: rtl/ndefp_cfg.sv
// ----------------------------------------------------------------------------
// NDEF parser configuration registers
// APB-style register file holding the payload limit and the single-record
// mode bit. Writes complete in the access phase; pready is always high.
// ----------------------------------------------------------------------------
module ndefp_cfg
    import ndefp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output parser_cfg_t cfg
);

    logic [31:0] max_payload_reg;
    logic        single_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
            single_reg      <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_MAX_PAYLOAD: max_payload_reg <= pwdata;
                REG_SINGLE:      single_reg      <= pwdata[0];
                default:         max_payload_reg <= max_payload_reg;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        unique case (reg_sel)
            REG_MAX_PAYLOAD: prdata = max_payload_reg;
            REG_SINGLE:      prdata = {31'd0, single_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.max_payload        = max_payload_reg;
    assign cfg.single_record_mode = single_reg;

endmodule

// File: rtl/ndefp_step.sv
// ----------------------------------------------------------------------------
// NDEF parser byte step
// Combinational next-state and result logic for one message byte: header
// rule checks, length capture, chunk merging, record completion and the
// end-of-buffer checks.
// ----------------------------------------------------------------------------
module ndefp_step
    import ndefp_pkg::*;
#(
    parameter int LONG_LENGTH_BITS = 32
)
(
    input  parse_state_t cur,
    input  parser_cfg_t  cfg,
    input  logic [7:0]   in_byte,
    input  logic         in_last,
    output parse_state_t nxt,
    output byte_result_t res
);

    localparam int LEN_BYTES = (LONG_LENGTH_BITS + 7) / 8;
    localparam logic [32:0] LEN_MASK_W = (33'd1 << LONG_LENGTH_BITS) - 33'd1;
    localparam logic [31:0] LEN_MASK = LEN_MASK_W[31:0];

    logic        hdr_bad;
    logic        mb;
    logic        me;
    logic        cf;
    logic        il;
    logic [2:0]  hdr_tnf;
    logic [2:0]  cur_tnf;
    logic [2:0]  seg_tnf;
    logic        fin;
    logic        adv;
    logic        comp;
    logic [32:0] sum;
    logic [2:0]  err;

    // TNF against the presence of type, ID and payload.
    function automatic logic tnf_acceptable(input logic [2:0] tnf, input logic has_type,
                                            input logic has_id, input logic empty_pay);
        logic ok;
        begin
            unique case (tnf)
                TNF_VOID:       ok = !has_type && !has_id && empty_pay;
                TNF_WKT,
                TNF_MEDIA,
                TNF_URI,
                TNF_EXTERNAL:   ok = 1'b1;
                TNF_OPAQUE,
                TNF_SPARE:      ok = !has_type;
                TNF_CONT:       ok = 1'b0;
                default:        ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

    // Header rule checks.
    assign mb      = in_byte[FLAG_MB];
    assign me      = in_byte[FLAG_ME];
    assign cf      = in_byte[FLAG_CF];
    assign il      = in_byte[FLAG_IL];
    assign hdr_tnf = in_byte[2:0];
    assign hdr_bad = (!cfg.single_record_mode && !mb && !cur.record_seen && !cur.chunk_open)
                   || (!cfg.single_record_mode && mb && (cur.record_seen || cur.chunk_open))
                   || (cur.chunk_open && il) || (cf && me)
                   || (cur.chunk_open && hdr_tnf != TNF_CONT)
                   || (!cur.chunk_open && hdr_tnf == TNF_CONT);

    assign cur_tnf = cur.chunk_open ? cur.chunk_format : cur.header_flags[2:0];

    // Per-byte state update.
    always_comb
    begin
        nxt          = cur;
        res          = '0;
        res.out_byte = in_byte & BYTE_MASK;
        res.byte_kind = KIND_IGNORED;
        err          = ERR_NONE;
        fin          = 1'b0;
        adv          = 1'b0;
        comp         = 1'b0;
        sum          = 33'd0;
        seg_tnf      = 3'd0;

        if (!cur.halted)
        begin
            unique case (cur.phase)
                PH_HEAD:
                begin
                    res.byte_kind  = KIND_HEADER;
                    res.record_tnf = cur.chunk_open ? cur.chunk_format : hdr_tnf;
                    if (hdr_bad)
                    begin
                        err = ERR_FLAGS;
                    end
                    else
                    begin
                        nxt.header_flags = in_byte;
                        if (!cur.chunk_open)
                        begin
                            nxt.merged_length = 32'd0;
                            nxt.kept_type     = 1'b0;
                            nxt.kept_id       = 1'b0;
                            nxt.type_count    = 8'd0;
                            nxt.id_count      = 8'd0;
                            res.record_start  = 1'b1;
                        end
                        nxt.payload_count     = 32'd0;
                        nxt.length_byte_index = 2'd0;
                        nxt.phase             = PH_TLEN;
                    end
                end
                PH_TLEN:
                begin
                    res.byte_kind  = KIND_TLEN;
                    res.record_tnf = cur_tnf;
                    if (cur.chunk_open)
                    begin
                        if (in_byte != 8'd0)
                        begin
                            err = ERR_LENGTH;
                        end
                    end
                    else if (cur.header_flags[FLAG_CF] && in_byte == 8'd0
                             && cur.header_flags[2:0] != TNF_OPAQUE)
                    begin
                        err = ERR_LENGTH;
                    end
                    else
                    begin
                        nxt.type_count = in_byte;
                        nxt.kept_type  = in_byte != 8'd0;
                    end
                    nxt.phase = PH_PLEN;
                end
                PH_PLEN:
                begin
                    res.byte_kind  = KIND_PLEN;
                    res.record_tnf = cur_tnf;
                    if (cur.header_flags[FLAG_SR])
                    begin
                        nxt.payload_count = {24'd0, in_byte};
                        fin = 1'b1;
                    end
                    else
                    begin
                        nxt.payload_count = {cur.payload_count[23:0], in_byte} & LEN_MASK;
                        fin = ({1'b0, cur.length_byte_index} + 3'd1) >= 3'(LEN_BYTES);
                        nxt.length_byte_index = cur.length_byte_index + 2'd1;
                    end
                    if (fin)
                    begin
                        sum = {1'b0, cur.merged_length} + {1'b0, nxt.payload_count};
                        if (nxt.payload_count > cfg.max_payload)
                        begin
                            err = ERR_LENGTH;
                        end
                        else if ((cur.chunk_open || cur.header_flags[FLAG_CF])
                                 && sum > {1'b0, cfg.max_payload})
                        begin
                            err = ERR_OVER;
                        end
                        else
                        begin
                            nxt.merged_length = sum[31:0];
                            if (cur.header_flags[FLAG_IL])
                            begin
                                nxt.phase = PH_ILEN;
                            end
                            else
                            begin
                                adv = 1'b1;
                            end
                        end
                    end
                end
                PH_ILEN:
                begin
                    res.byte_kind  = KIND_ILEN;
                    res.record_tnf = cur_tnf;
                    nxt.id_count   = in_byte;
                    nxt.kept_id    = in_byte != 8'd0;
                    adv = 1'b1;
                end
                PH_TYPE:
                begin
                    res.byte_kind  = KIND_TYPE;
                    res.record_tnf = cur_tnf;
                    nxt.type_count = cur.type_count - 8'd1;
                    adv = nxt.type_count == 8'd0;
                end
                PH_ID:
                begin
                    res.byte_kind  = KIND_ID;
                    res.record_tnf = cur_tnf;
                    nxt.id_count   = cur.id_count - 8'd1;
                    adv = nxt.id_count == 8'd0;
                end
                default:
                begin
                    res.byte_kind  = KIND_PAYLOAD;
                    res.record_tnf = cur_tnf;
                    if (cur.payload_count != 32'd0)
                    begin
                        nxt.payload_count = cur.payload_count - 32'd1;
                    end
                    comp = nxt.payload_count == 32'd0;
                end
            endcase

            // Move on to the next declared field of the record.
            if (adv)
            begin
                priority if (nxt.type_count != 8'd0)
                begin
                    nxt.phase = PH_TYPE;
                end
                else if (nxt.id_count != 8'd0)
                begin
                    nxt.phase = PH_ID;
                end
                else if (nxt.payload_count != 32'd0)
                begin
                    nxt.phase = PH_PAY;
                end
                else
                begin
                    comp = 1'b1;
                end
            end

            // Close a chunk or a whole logical record.
            if (comp)
            begin
                nxt.phase = PH_HEAD;
                if (nxt.header_flags[FLAG_CF])
                begin
                    if (!nxt.chunk_open)
                    begin
                        nxt.chunk_format = nxt.header_flags[2:0];
                    end
                    nxt.chunk_open = 1'b1;
                end
                else
                begin
                    seg_tnf = nxt.chunk_open ? nxt.chunk_format : nxt.header_flags[2:0];
                    res.record_end = 1'b1;
                    res.tnf_ok = tnf_acceptable(seg_tnf, nxt.kept_type, nxt.kept_id,
                                                nxt.merged_length == 32'd0);
                    nxt.record_seen   = 1'b1;
                    nxt.chunk_open    = 1'b0;
                    nxt.merged_length = 32'd0;
                    if (nxt.header_flags[FLAG_ME] || cfg.single_record_mode)
                    begin
                        res.message_done = 1'b1;
                        nxt.halted       = 1'b1;
                    end
                end
            end

            // Errors halt the parser; the buffer end checks for a cut-off message.
            if (err != ERR_NONE)
            begin
                nxt.halted       = 1'b1;
                res.record_end   = 1'b0;
                res.tnf_ok       = 1'b0;
                res.message_done = 1'b0;
            end
            else if (in_last && !nxt.halted)
            begin
                err = (nxt.type_count != 8'd0 || nxt.id_count != 8'd0) ? ERR_MISSING
                                                                         : ERR_TRUNCATED;
            end
            res.error_code = err;
        end

        if (in_last)
        begin
            nxt = STATE_RESET;
        end
    end

endmodule

// File: rtl/ndef_message_parser_unit.sv
// ----------------------------------------------------------------------------
// NDEF message parser unit
// Tags each byte of an NDEF message stream and checks the record rules.
// ----------------------------------------------------------------------------
// Usage:
// Bytes of the message enter on the s_ stream, one item per byte, with
// s_tlast on the final byte of the buffer. Each byte gives exactly one result
// item on the m_ stream: the byte itself, its kind, the record TNF and the
// record, message and error flags; m_tlast marks the byte that completes a
// logical record.
// Throughput is one byte per cycle while the receiver takes results. A byte
// is first captured in the input register, the parse step runs on it and its
// result is loaded into the output register together with the new parse state.
// When the receiver stalls, the result is held, the input register fills and
// s_tready falls; no item is lost or repeated.
// Reset clears the parse state and the handshake registers and loads the
// configuration registers with their defaults. The APB port sets the
// payload limit (address 0) and single-record mode (address 4); write it
// only while no byte is in flight.
// ----------------------------------------------------------------------------
module ndef_message_parser_unit
    import ndefp_pkg::*;
#(
    parameter int LONG_LENGTH_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [10:8] record_tnf, [11] record_start,
                                   // [12] tnf_ok, [13] message_done, [16:14] error_code
    output logic [2:0]  m_tuser,   // [2:0] byte_kind
    output logic        m_tlast,   // record_end
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    parser_cfg_t  cfg;
    parse_state_t state_reg;
    parse_state_t state_next;
    byte_result_t step_res;
    byte_result_t res_reg;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    logic         fire;

    ndefp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ndefp_step #(
        .LONG_LENGTH_BITS (LONG_LENGTH_BITS)
    ) u_step (
        .cur     (state_reg),
        .cfg     (cfg),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .nxt     (state_next),
        .res     (step_res)
    );

    // The step fires when a byte is waiting and the result slot is free.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, res_reg.error_code, res_reg.message_done, res_reg.tnf_ok,
                       res_reg.record_start, res_reg.record_tnf, res_reg.out_byte};
    assign m_tuser  = res_reg.byte_kind;
    assign m_tlast  = res_reg.record_end;

endmodule
